FILE: src/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg: shared types and constants of the HMM Viterbi decoder
// Payload structs, operation codes and default sizes.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int STATES_DEF      = 8;
  localparam int SYMBOLS_DEF     = 16;
  localparam int MAX_STEPS_DEF   = 64;
  localparam int COST_BITS_DEF   = 16;
  localparam int METRIC_BITS_DEF = 24;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_TRANS = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;
  localparam logic [1:0] OP_OBS   = 2'd3;

  localparam logic CFG_STATES  = 1'b0;
  localparam logic CFG_SYMBOLS = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  from_state;
    logic [2:0]  to_state;
    logic [3:0]  symbol;
    logic [15:0] cost;
    logic        is_last;
  } in_word_t;

  typedef struct packed {
    logic [5:0] time_index;
    logic [2:0] state_index;
    logic       run_end;
  } out_word_t;

endpackage

FILE: src/hvd_front.sv
// ----------------------------------------------------------------------------
// hvd_front: input stage
// Accepts input words into a small queue that feeds the back end.
// ----------------------------------------------------------------------------
module hvd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hvd_pkg::in_word_t in_data,
  output logic             q_valid,
  input  logic             q_ready,
  output hvd_pkg::in_word_t q_data
);
  import hvd_pkg::*;

  in_word_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/hvd_back.sv
// ----------------------------------------------------------------------------
// hvd_back: table storage, add-compare-select sequencer and traceback
// One state pair is compared per cycle; back-pointers live in a memory.
// ----------------------------------------------------------------------------
module hvd_back #(
  parameter int STATES      = hvd_pkg::STATES_DEF,
  parameter int SYMBOLS     = hvd_pkg::SYMBOLS_DEF,
  parameter int MAX_STEPS   = hvd_pkg::MAX_STEPS_DEF,
  parameter int COST_BITS   = hvd_pkg::COST_BITS_DEF,
  parameter int METRIC_BITS = hvd_pkg::METRIC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  hvd_pkg::in_word_t  q_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hvd_pkg::out_word_t out_data
);
  import hvd_pkg::*;

  localparam int SB = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int YB = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int TB = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int NB = $clog2(STATES + 1);
  localparam int MB = $clog2(SYMBOLS + 1);
  localparam int CB = $clog2(MAX_STEPS + 1);
  localparam logic [COST_BITS-1:0]   CMAX = {COST_BITS{1'b1}};
  localparam logic [METRIC_BITS-1:0] MMAX = {METRIC_BITS{1'b1}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_ACS  = 7'b0000010, S_EMIT = 7'b0000100,
    S_BEST = 7'b0001000, S_TB   = 7'b0010000, S_WAIT = 7'b0100000,
    S_FET  = 7'b1000000
  } st_t;

  st_t st_r;
  logic [3:0] act_st_r;
  logic [4:0] act_sy_r;
  logic [NB-1:0] n_eff;
  logic [MB-1:0] y_eff;

  logic [COST_BITS-1:0] init_r  [STATES];
  logic [STATES-1:0]    init_v_r;
  logic [COST_BITS-1:0] trans_r [STATES*STATES];
  logic [STATES*STATES-1:0] trans_v_r;
  logic [COST_BITS-1:0] emit_r  [STATES*SYMBOLS];
  logic [STATES*SYMBOLS-1:0] emit_v_r;
  logic [METRIC_BITS-1:0] pm_r [STATES];
  logic [METRIC_BITS-1:0] nm_r [STATES];
  logic [SB-1:0] bp_mem [MAX_STEPS*STATES];
  logic [SB-1:0] bp_rd_r;

  logic [CB-1:0] tstep_r;
  logic [SB-1:0] i_r, j_r, best_i_r, s_r;
  logic [METRIC_BITS-1:0] best_m_r;
  logic [YB:0] sym_r;
  logic last_r;
  logic [TB-1:0] t_r;

  logic in_op_ok;
  always_comb begin
    n_eff = (act_st_r == 4'd0) ? NB'(1) :
            ({28'd0, act_st_r} > STATES) ? NB'(STATES) : NB'(act_st_r);
    y_eff = (act_sy_r == 5'd0) ? MB'(1) :
            ({27'd0, act_sy_r} > SYMBOLS) ? MB'(SYMBOLS) : MB'(act_sy_r);
  end

  function automatic logic [METRIC_BITS-1:0] sat_add(
      input logic [METRIC_BITS-1:0] m, input logic [COST_BITS-1:0] c);
    logic [METRIC_BITS:0] s;
    s = {1'b0, m} + (METRIC_BITS+1)'(c);
    if (m == MMAX || c == CMAX || s >= {1'b0, MMAX}) return MMAX;
    return s[METRIC_BITS-1:0];
  endfunction

  // Table reads are registered: the transition read runs one candidate ahead,
  // and the emission read is settled by the fetch cycle of each state.
  logic [COST_BITS-1:0] trr_r, emr_r;
  logic trx_r, emx_r;
  logic [SB+SB-1:0] tr_raddr, tr_waddr;
  logic [SB+YB-1:0] eidx, em_waddr;
  logic tr_we, em_we;

  assign eidx     = {j_r, sym_r[YB-1:0]};
  assign tr_raddr = {(st_r == S_ACS) ? i_r + SB'(1) : i_r, j_r};
  assign tr_waddr = {SB'(q_data.from_state), SB'(q_data.to_state)};
  assign em_waddr = {SB'(q_data.to_state), YB'(q_data.symbol)};
  assign tr_we = in_op_ok && (q_data.operation == OP_TRANS) &&
                 (32'(q_data.to_state) < STATES) && (32'(q_data.from_state) < STATES);
  assign em_we = in_op_ok && (q_data.operation == OP_EMIT) &&
                 (32'(q_data.to_state) < STATES) && (32'(q_data.symbol) < SYMBOLS);

  // Emission cost of state j for the observed symbol (impossible if unused).
  logic [COST_BITS-1:0] emc;
  assign emc = emx_r ? CMAX : emr_r;

  logic [COST_BITS-1:0] trc;
  logic [METRIC_BITS-1:0] cand;
  always_comb begin
    trc  = trx_r ? CMAX : trr_r;
    cand = sat_add(pm_r[i_r], trc);
  end

  logic j_act, i_last, j_last;
  assign j_act  = (NB'(j_r) < n_eff);
  assign i_last = (NB'(i_r) + NB'(1) >= n_eff);
  assign j_last = (j_r == SB'(STATES - 1));

  assign q_ready   = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_op_ok  = q_valid && q_ready;

  logic [TB+SB-1:0] bp_waddr;
  logic             bp_we;
  assign bp_waddr = {tstep_r[TB-1:0], j_r};

  // Back-pointer, transition and emission memories.
  always_ff @(posedge clk) begin
    if (bp_we) bp_mem[bp_waddr] <= j_act ? best_i_r : SB'(0);
    bp_rd_r <= bp_mem[{t_r, s_r}];
    if (tr_we) trans_r[tr_waddr] <= q_data.cost[COST_BITS-1:0];
    trr_r <= trans_r[tr_raddr];
    trx_r <= !trans_v_r[tr_raddr];
    if (em_we) emit_r[em_waddr] <= q_data.cost[COST_BITS-1:0];
    emr_r <= emit_r[eidx];
    emx_r <= ({{(32-YB-1){1'b0}}, sym_r} >= 32'(y_eff)) || !emit_v_r[eidx];
  end

  logic tb_fetch_r;
  logic out_valid_r;
  logic out_load;
  out_word_t out_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign bp_we = (st_r == S_EMIT) && (tstep_r != CB'(0));
  assign out_load = (st_r == S_TB) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; act_st_r <= 4'd8; act_sy_r <= 5'd16;
      init_v_r <= '0; trans_v_r <= '0; emit_v_r <= '0;
      tstep_r <= '0; out_valid_r <= 1'b0; tb_fetch_r <= 1'b0;
      for (int k = 0; k < STATES; k++) pm_r[k] <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_STATES) act_st_r <= cfg_data[3:0];
        else act_sy_r <= cfg_data[4:0];
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_op_ok) begin
          case (q_data.operation)
            OP_INIT: if (32'(q_data.to_state) < STATES) begin
              init_r[SB'(q_data.to_state)] <= q_data.cost[COST_BITS-1:0];
              init_v_r[SB'(q_data.to_state)] <= 1'b1;
            end
            OP_TRANS: if (tr_we) begin
              trans_v_r[tr_waddr] <= 1'b1;
            end
            OP_EMIT: if (em_we) begin
              emit_v_r[em_waddr] <= 1'b1;
            end
            default: begin
              sym_r  <= (32'(q_data.symbol) < SYMBOLS) ?
                        (YB+1)'(q_data.symbol) : (YB+1)'(SYMBOLS);
              last_r <= q_data.is_last;
              if (tstep_r >= CB'(MAX_STEPS)) tstep_r <= '0;
              i_r <= '0; j_r <= '0;
              best_m_r <= MMAX; best_i_r <= '0;
              st_r <= S_FET;
            end
          endcase
        end
        S_FET: begin
          st_r <= ((tstep_r != CB'(0)) && j_act) ? S_ACS : S_EMIT;
        end
        S_ACS: begin
          if (i_r == SB'(0) || cand < best_m_r) begin
            best_m_r <= cand; best_i_r <= i_r;
          end
          if (i_last) st_r <= S_EMIT;
          else i_r <= i_r + SB'(1);
        end
        S_EMIT: begin
          if (tstep_r == CB'(0)) begin
            pm_r[j_r] <= j_act ? sat_add((init_v_r[j_r] && init_r[j_r] != CMAX) ?
                         METRIC_BITS'(init_r[j_r]) : MMAX, emc) : MMAX;
          end else begin
            nm_r[j_r] <= j_act ? sat_add(best_m_r, emc) : MMAX;
          end
          i_r <= '0; best_m_r <= MMAX; best_i_r <= '0;
          if (j_last) begin
            if (tstep_r != CB'(0))
              for (int k = 0; k < STATES; k++)
                pm_r[k] <= (k == STATES-1) ? (j_act ? sat_add(best_m_r, emc) : MMAX)
                                          : nm_r[k];
            tstep_r <= tstep_r + CB'(1);
            if (last_r || (tstep_r + CB'(1) >= CB'(MAX_STEPS))) begin
              st_r <= S_BEST; j_r <= '0; s_r <= '0;
              t_r <= TB'(tstep_r);
            end else st_r <= S_IDLE;
          end else begin
            j_r <= j_r + SB'(1);
            st_r <= S_FET;
          end
        end
        S_BEST: begin
          // Scan metrics for the final state, lowest index on ties.
          if (NB'(j_r) < n_eff && pm_r[j_r] < pm_r[s_r]) s_r <= j_r;
          if (j_last) begin st_r <= S_TB; tb_fetch_r <= 1'b0; end
          else j_r <= j_r + SB'(1);
        end
        S_TB: if (out_load) begin
          out_r.time_index  <= 6'(t_r);
          out_r.state_index <= 3'(s_r);
          out_r.run_end     <= (t_r == TB'(0));
          if (t_r == TB'(0)) begin
            st_r <= S_IDLE; tstep_r <= '0;
          end else st_r <= S_WAIT;
        end
        S_WAIT: begin
          // The back-pointer memory read for {t, s} is registered; tb_fetch_r marks when it is taken.
          if (tb_fetch_r) begin
            s_r <= bp_rd_r; t_r <= t_r - TB'(1); st_r <= S_TB;
            tb_fetch_r <= 1'b0;
          end else tb_fetch_r <= 1'b1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/hmm_viterbi_decoder.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder: HMM Viterbi decoder, top level
// Channel | dir | handshake            | payload
// in      | in  | in_valid/in_ready    | in_data (in_word_t)
// out     | out | out_valid/out_ready  | out_data (out_word_t)
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// The time an observation takes is set by the single add-compare-select unit
// and a table read per state. The time traceback takes per decoded word is
// set by the back-pointer memory read. Reset is synchronous; a stalled output
// holds traceback.
// ----------------------------------------------------------------------------
module hmm_viterbi_decoder #(
  parameter int STATES      = hvd_pkg::STATES_DEF,
  parameter int SYMBOLS     = hvd_pkg::SYMBOLS_DEF,
  parameter int MAX_STEPS   = hvd_pkg::MAX_STEPS_DEF,
  parameter int COST_BITS   = hvd_pkg::COST_BITS_DEF,
  parameter int METRIC_BITS = hvd_pkg::METRIC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hvd_pkg::in_word_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hvd_pkg::out_word_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import hvd_pkg::*;

  logic     q_valid, q_ready;
  in_word_t q_data;

  hvd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  hvd_back #(
    .STATES(STATES), .SYMBOLS(SYMBOLS), .MAX_STEPS(MAX_STEPS),
    .COST_BITS(COST_BITS), .METRIC_BITS(METRIC_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: src/hvd_checker.sv
// ----------------------------------------------------------------------------
// hvd_checker: port-level checks for the decoder
// Watches the output channel and the traceback order.
// ----------------------------------------------------------------------------
module hvd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input hvd_pkg::out_word_t out_data
);
  import hvd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_end == (out_data.time_index == 6'd0)))
    else $error("run end flag disagrees with time index");

  a_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_end ##1 out_valid |->
      out_data.time_index == $past(out_data.time_index) - 6'd1 ||
      out_data.time_index == $past(out_data.time_index))
    else $error("traceback time index out of order");

endmodule

bind hmm_viterbi_decoder hvd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);

FILE: tb/hmm_viterbi_decoder_tb.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder_tb: self-checking testbench of the HMM Viterbi decoder
// Loads cost tables, sends observation sequences and compares each decoded
// word with a behavioral predictor of the decoder, under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmm_viterbi_decoder_tb;
  import hvd_pkg::*;

  localparam int NS = 8;
  localparam int NSYM = 16;
  localparam int STEPS = 64;
  localparam logic [23:0] UNREACH = 24'hFFFFFF;
  localparam logic [15:0] IMPOSSIBLE = 16'hFFFF;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  hmm_viterbi_decoder i_dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [3:0] m_states;
  logic [4:0] m_symbols;
  logic [23:0] metric [NS];
  logic [2:0] bptr [STEPS][NS];
  logic [15:0] trans [NS][NS];
  logic [15:0] emis [NS][NSYM];
  logic [15:0] init_c [NS];
  int step_cnt;

  out_word_t decoded_q[$];
  // Rows carrying a typed-in expectation instead of the predictor's.
  bit typed_row;
  out_word_t typed_q[$];
  bit failed = 1'b0;
  int idle_cycles = 0;
  bit stall_out = 1'b1;

  function automatic logic [23:0] cost_sum(logic [23:0] m, logic [15:0] c);
    logic [24:0] s;
    if (m == UNREACH || c == IMPOSSIBLE) return UNREACH;
    s = {1'b0, m} + {9'd0, c};
    return (s >= {1'b0, UNREACH}) ? UNREACH : s[23:0];
  endfunction

  function automatic int live_states();
    if (m_states == 0) return 1;
    return (m_states > NS) ? NS : int'(m_states);
  endfunction

  function automatic logic [15:0] emis_of(int st, logic [3:0] sym);
    int ns;
    ns = (m_symbols == 0) ? 1 : ((m_symbols > NSYM) ? NSYM : int'(m_symbols));
    return (int'(sym) >= ns) ? IMPOSSIBLE : emis[st][sym];
  endfunction

  task automatic predict_word(in_word_t w);
    int n, best, s;
    logic [23:0] nm [NS];
    logic [23:0] bm, m;
    out_word_t r;
    n = live_states();
    case (w.operation)
      OP_INIT: init_c[w.to_state] = w.cost;
      OP_TRANS: trans[w.from_state][w.to_state] = w.cost;
      OP_EMIT: emis[w.to_state][w.symbol] = w.cost;
      default: begin
        if (step_cnt >= STEPS) step_cnt = 0;
        if (step_cnt == 0) begin
          for (int j = 0; j < NS; j++)
            metric[j] = (j < n) ? cost_sum((init_c[j] == IMPOSSIBLE) ? UNREACH
                        : {8'd0, init_c[j]}, emis_of(j, w.symbol)) : UNREACH;
        end else begin
          for (int j = 0; j < NS; j++) begin
            bm = UNREACH;
            best = 0;
            if (j < n) begin
              bm = cost_sum(metric[0], trans[0][j]);
              for (int i = 1; i < n; i++) begin
                m = cost_sum(metric[i], trans[i][j]);
                if (m < bm) begin
                  bm = m;
                  best = i;
                end
              end
              bm = cost_sum(bm, emis_of(j, w.symbol));
            end
            nm[j] = bm;
            bptr[step_cnt][j] = 3'(best);
          end
          metric = nm;
        end
        step_cnt++;
        if (w.is_last || step_cnt >= STEPS) begin
          best = 0;
          for (int i = 1; i < n; i++)
            if (metric[i] < metric[best]) best = i;
          s = best;
          for (int t = step_cnt - 1; t >= 0; t--) begin
            r.time_index = 6'(t);
            r.state_index = 3'(s);
            r.run_end = (t == 0);
            if (typed_row) begin
              if (typed_q.size() == 0 || typed_q[0] != r) begin
                $display("%0t: typed expectation %p, predictor %p", $time,
                         (typed_q.size() != 0) ? typed_q[0] : '0, r);
                failed = 1'b1;
              end
              if (typed_q.size() != 0) r = typed_q.pop_front();
            end
            decoded_q.push_back(r);
            if (t > 0) s = int'(bptr[t][s]);
          end
          step_cnt = 0;
        end
      end
    endcase
  endtask

  task automatic reset_model();
    m_states = 4'd8;
    m_symbols = 5'd16;
    step_cnt = 0;
    foreach (metric[i]) metric[i] = '0;
    foreach (init_c[i]) init_c[i] = IMPOSSIBLE;
    foreach (trans[i, j]) trans[i][j] = IMPOSSIBLE;
    foreach (emis[i, j]) emis[i][j] = IMPOSSIBLE;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays high after an accepted word until the next word or a gap.
  task automatic send_word(in_word_t w);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STATES) m_states = val[3:0];
    else m_symbols = val[4:0];
    @(posedge clk);
  endtask

  function automatic in_word_t mk(logic [1:0] op, int fr, int to, int sym,
                                  int cost, bit last);
    in_word_t w;
    w.operation = op;
    w.from_state = 3'(fr);
    w.to_state = 3'(to);
    w.symbol = 4'(sym);
    w.cost = 16'(cost);
    w.is_last = last;
    return w;
  endfunction

  // Result side: random stalls and the comparison.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, out_data);
          failed = 1'b1;
        end else begin
          out_word_t e;
          e = decoded_q.pop_front();
          if (e.time_index != out_data.time_index ||
              e.state_index != out_data.state_index ||
              e.run_end != out_data.run_end) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
            failed = 1'b1;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_out <= ~stall_out;
      out_ready <= stall_out ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Watchdog on cycles with no accepted word on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  in_word_t table_rows[$];
  int cfg_states_set[] = '{0, 1, 3, 15, 8};
  int cfg_symbols_set[] = '{0, 31, 5, 16, 1};

  initial begin
    in_word_t w;
    int len, ns;
    reset_model();
    typed_row = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset every path is unreachable, so ties pick state zero.
    typed_q.push_back(out_word_t'{time_index: 6'd1, state_index: 3'd0, run_end: 1'b0});
    typed_q.push_back(out_word_t'{time_index: 6'd0, state_index: 3'd0, run_end: 1'b1});
    table_rows.push_back(mk(OP_OBS, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(OP_OBS, 7, 7, 15, 16'hFFFF, 1));
    // Extremes of costs, a single-state chain and an unused symbol.
    table_rows.push_back(mk(OP_INIT, 0, 3, 0, 0, 1));
    table_rows.push_back(mk(OP_INIT, 0, 7, 0, 16'hFFFE, 0));
    table_rows.push_back(mk(OP_TRANS, 3, 7, 0, 0, 0));
    table_rows.push_back(mk(OP_TRANS, 7, 3, 0, 16'hFFFF, 1));
    table_rows.push_back(mk(OP_TRANS, 7, 7, 0, 16'hFFFE, 0));
    table_rows.push_back(mk(OP_EMIT, 0, 3, 15, 0, 0));
    table_rows.push_back(mk(OP_EMIT, 0, 7, 0, 16'hFFFE, 0));
    table_rows.push_back(mk(OP_EMIT, 0, 3, 0, 7, 0));
    table_rows.push_back(mk(OP_OBS, 0, 0, 15, 0, 0));
    table_rows.push_back(mk(OP_OBS, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(OP_OBS, 5, 2, 9, 16'h1234, 1));
    foreach (table_rows[k]) begin
      typed_row = (k < 2);
      send_word(table_rows[k]);
    end
    typed_row = 1'b0;
    wait_drain();

    // A full step-limit sequence over random tables.
    for (int i = 0; i < 30; i++)
      send_word(mk($urandom_range(0, 2), $urandom_range(0, 7), $urandom_range(0, 7),
                   $urandom_range(0, 15), $urandom_range(0, 2000), $urandom_range(0, 1)));
    for (int i = 0; i < STEPS; i++)
      send_word(mk(OP_OBS, $urandom, $urandom, $urandom_range(0, 15), $urandom, 1'b0));
    wait_drain();

    foreach (cfg_states_set[p]) begin
      write_reg(CFG_STATES, cfg_states_set[p]);
      write_reg(CFG_SYMBOLS, cfg_symbols_set[p]);
      ns = $urandom_range(30, 40);
      for (int n = 0; n < ns; ) begin
        if ($urandom_range(0, 3) == 0) begin
          // Table write with wide random content, including impossible costs.
          w = mk($urandom_range(0, 2), $urandom, $urandom, $urandom,
                 ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 65535) >>
                 $urandom_range(0, 12), $urandom);
          send_word(w);
          n++;
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4);
          for (int t = 0; t < len; t++) begin
            w = mk(OP_OBS, $urandom, $urandom, $urandom_range(0, 15), $urandom,
                   t == len - 1);
            send_word(w);
          end
          n += len;
        end
      end
      wait_drain();
    end

    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/hvd_pkg.sv
src/hvd_front.sv
src/hvd_back.sv
src/hmm_viterbi_decoder.sv
src/hvd_checker.sv
tb/hmm_viterbi_decoder_tb.sv
